// ===== design/sprc_pkg.sv =====
// Shared types and constants of the sensor response packet checker.
package sprc_pkg;

    // Field widths of the stream and the configuration port.
    localparam int unsigned POS_W      = 17;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned OUT_DATA_W = 64;

    // Start code words as assembled little-endian from the first two bytes.
    localparam logic [15:0] RESP_START = 16'hAA55;
    localparam logic [15:0] DATA_START = 16'hA55A;

    // Byte positions within a packet.
    localparam logic [POS_W-1:0] HEADER_LEN   = 17'd4;
    localparam logic [POS_W-1:0] RESP_CHK_POS = 17'd10;
    localparam logic [POS_W-1:0] PARAM_END    = 17'd8;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXPECT_DATA = 2'd0,
        REG_PAYLOAD_LEN = 2'd1,
        REG_DEVICE_ID   = 2'd2,
        REG_NACK_CODE   = 2'd3
    } cfg_index_t;

    // Kind of a result transaction, carried in tuser.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } result_kind_t;

    // Packet status codes.
    typedef enum logic [1:0] {
        STATUS_ACK   = 2'd0,
        STATUS_NACK  = 2'd1,
        STATUS_ERROR = 2'd2
    } packet_status_t;

endpackage

// ===== design/sensor_response_packet_checker.sv =====
// Top level of the sensor response packet checker.
//
// Usage: received link bytes enter on the s_axis channel, one byte per
// transaction. The block frames packets purely by byte count: in response
// mode a packet is 12 bytes, in data mode it is 6 bytes plus payload_length.
// Each payload byte of a data packet leaves on m_axis as a payload result
// (tuser = 0); the last byte of a packet yields one status result
// (tuser = 1) with ack, nack or error, plus the parameter and response code
// of a valid response packet. Other bytes produce no result.
// Configuration is written through cfg_we / cfg_index / cfg_data and takes
// effect on the next byte.
// A result is presented in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the output stalls; a byte step is
// a running-sum add, position compares against the checksum position and
// field bounds, and a counter increment feeding a single output register.
// Reset returns the registers to their defaults and clears the packet state.
// When the receiver stalls, the output register holds its result and input
// is taken only if the held result leaves in the same cycle.
module sensor_response_packet_checker
    import sprc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // rx_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // payload_byte[7:0], packet_status[9:8], param_value[41:10],
    // response_code[57:42], zero fill[63:58]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tuser   // result_kind
);

    // Configuration registers.
    logic        expect_data_reg;
    logic [15:0] payload_len_reg;
    logic [15:0] device_id_reg;
    logic [15:0] nack_code_reg;

    // Packet state.
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      sum_reg, sum_next;
    logic [15:0]      start_reg, start_next;
    logic [15:0]      dev_reg, dev_next;
    logic [31:0]      param_reg, param_next;
    logic [15:0]      resp_reg, resp_next;
    logic [7:0]       chk_lo_reg, chk_lo_next;

    // Output register.
    logic                  m_valid_reg, m_valid_next;
    logic                  m_user_reg, m_user_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic             in_accept;
    logic [POS_W-1:0] chk_pos;
    logic [15:0]      want_start;
    logic [15:0]      rx_chk;
    logic             bad_packet;
    logic [7:0]       b;
    packet_status_t   status;

    assign b             = s_axis_tdata;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Checksum position and expected start code of the current mode.
    assign chk_pos    = expect_data_reg ? (HEADER_LEN + {1'b0, payload_len_reg})
                                        : RESP_CHK_POS;
    assign want_start = expect_data_reg ? DATA_START : RESP_START;
    assign rx_chk     = {b, chk_lo_reg};
    assign bad_packet = (start_reg != want_start) || (dev_reg != device_id_reg)
                        || (rx_chk != sum_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_data_reg <= 1'b0;
            payload_len_reg <= 16'd0;
            device_id_reg   <= 16'd1;
            nack_code_reg   <= 16'd49;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECT_DATA: expect_data_reg <= cfg_data[0];
                REG_PAYLOAD_LEN: payload_len_reg <= cfg_data;
                REG_DEVICE_ID:   device_id_reg   <= cfg_data;
                REG_NACK_CODE:   nack_code_reg   <= cfg_data;
                default:         expect_data_reg <= expect_data_reg;
            endcase
        end
    end

    // Byte step: field assembly, running sum and end of packet check.
    always_comb
    begin
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        start_next   = start_reg;
        dev_next     = dev_reg;
        param_next   = param_reg;
        resp_next    = resp_reg;
        chk_lo_next  = chk_lo_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_user_next  = m_user_reg;
        m_data_next  = m_data_reg;
        status       = STATUS_ACK;

        if (in_accept)
        begin
            m_user_next = KIND_PAYLOAD;
            m_data_next = '0;
            if (pos_reg < chk_pos)
            begin
                sum_next = sum_reg + {8'd0, b};
                pos_next = pos_reg + 1'b1;
                if (pos_reg < 17'd2)
                begin
                    if (pos_reg[0])
                        start_next[15:8] = start_reg[15:8] | b;
                    else
                        start_next[7:0] = start_reg[7:0] | b;
                end
                else if (pos_reg < HEADER_LEN)
                begin
                    if (pos_reg[0])
                        dev_next[15:8] = dev_reg[15:8] | b;
                    else
                        dev_next[7:0] = dev_reg[7:0] | b;
                end
                else if (expect_data_reg)
                begin
                    m_valid_next     = 1'b1;
                    m_data_next[7:0] = b;
                end
                else if (pos_reg < PARAM_END)
                begin
                    case (pos_reg[1:0])
                        2'd0:    param_next[7:0]   = param_reg[7:0]   | b;
                        2'd1:    param_next[15:8]  = param_reg[15:8]  | b;
                        2'd2:    param_next[23:16] = param_reg[23:16] | b;
                        default: param_next[31:24] = param_reg[31:24] | b;
                    endcase
                end
                else
                begin
                    if (pos_reg[0])
                        resp_next[15:8] = resp_reg[15:8] | b;
                    else
                        resp_next[7:0] = resp_reg[7:0] | b;
                end
            end
            else if (pos_reg == chk_pos)
            begin
                chk_lo_next = b;
                pos_next    = pos_reg + 1'b1;
            end
            else
            begin
                // Last byte: report status and clear the packet state.
                m_valid_next = 1'b1;
                m_user_next  = KIND_STATUS;
                if (bad_packet)
                    status = STATUS_ERROR;
                else if (expect_data_reg)
                    status = STATUS_ACK;
                else
                begin
                    status = (resp_reg == nack_code_reg) ? STATUS_NACK : STATUS_ACK;
                    m_data_next[41:10] = param_reg;
                    m_data_next[57:42] = resp_reg;
                end
                m_data_next[9:8] = status;
                pos_next    = '0;
                sum_next    = '0;
                start_next  = '0;
                dev_next    = '0;
                param_next  = '0;
                resp_next   = '0;
                chk_lo_next = '0;
            end
        end
    end

    // Packet state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            sum_reg     <= '0;
            start_reg   <= '0;
            dev_reg     <= '0;
            param_reg   <= '0;
            resp_reg    <= '0;
            chk_lo_reg  <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            sum_reg     <= sum_next;
            start_reg   <= start_next;
            dev_reg     <= dev_next;
            param_reg   <= param_next;
            resp_reg    <= resp_next;
            chk_lo_reg  <= chk_lo_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    // A payload result carries nothing but its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg == KIND_PAYLOAD) |-> (m_data_reg[63:8] == '0))
        else $error("payload result carries status fields");

    // The byte that ends a packet leaves the position at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && pos_reg > chk_pos) |=> (pos_reg == '0 && sum_reg == '0))
        else $error("packet state not cleared after status");

    // A status result never reports an undefined code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_user_reg == KIND_STATUS) |-> (m_data_reg[9:8] != 2'd3))
        else $error("undefined packet status");

    // Only the byte following the checksum position yields a status result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && pos_reg <= chk_pos) |=> !(m_valid_reg && m_user_reg == KIND_STATUS))
        else $error("status result before end of packet");

endmodule

// ===== bench/sensor_response_packet_checker_tb.sv =====
// Self-checking testbench for the sensor response packet checker.
`timescale 1ns / 1ps

module sensor_response_packet_checker_tb;
    import sprc_pkg::*;

    localparam int ITEM_TARGET = 1700;
    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    // One result transaction, split into its fields.
    typedef struct {
        result_kind_t   kind;
        logic [7:0]     payload;
        packet_status_t status;
        logic [31:0]    param;
        logic [15:0]    code;
    } sensor_result_t;

    // Byte-level predictor of the deframer plus the queue of results it owes.
    class sensor_link_scoreboard;
        logic           data_mode;
        logic [15:0]    pay_len;
        logic [15:0]    dev_id;
        logic [15:0]    nack_code;
        logic [16:0]    pos;
        logic [15:0]    sum;
        logic [15:0]    seen_start;
        logic [15:0]    seen_id;
        logic [15:0]    seen_resp;
        logic [31:0]    seen_param;
        logic [7:0]     chk_low;
        sensor_result_t pending[$];
        int             mismatches;
        int             payloads;
        int             acks;
        int             nacks;
        int             errors;

        function new();
            data_mode  = 1'b0;
            pay_len    = 16'd0;
            dev_id     = 16'd1;
            nack_code  = 16'd49;
            mismatches = 0;
            payloads   = 0;
            acks       = 0;
            nacks      = 0;
            errors     = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            pos        = '0;
            sum        = '0;
            seen_start = '0;
            seen_id    = '0;
            seen_resp  = '0;
            seen_param = '0;
            chk_low    = '0;
        endfunction

        // Position of the checksum low byte in the current mode.
        function logic [16:0] check_pos();
            return data_mode ? HEADER_LEN + 17'(pay_len) : RESP_CHK_POS;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] value);
            case (idx)
                REG_EXPECT_DATA: data_mode = value[0];
                REG_PAYLOAD_LEN: pay_len   = value;
                REG_DEVICE_ID:   dev_id    = value;
                REG_NACK_CODE:   nack_code = value;
                default: ;
            endcase
        endfunction

        // Bytes still needed to end the packet that is open, if any.
        function int bytes_to_close();
            logic [16:0] chk_at;
            chk_at = check_pos();
            if (pos == '0)
                return 0;
            if (pos > chk_at)
                return 1;
            return int'(chk_at) + 2 - int'(pos);
        endfunction

        // Account for one accepted link byte; queue the result it causes.
        function void note_rx_byte(logic [7:0] b);
            logic [16:0]    chk_at;
            logic [15:0]    want_start;
            logic [15:0]    rx_chk;
            sensor_result_t r;
            chk_at = check_pos();
            r = '{kind: KIND_PAYLOAD, payload: 8'h00, status: STATUS_ACK,
                  param: 32'h0, code: 16'h0};
            if (pos < chk_at) begin
                sum = sum + 16'(b);
                if (pos < 17'd2)
                    seen_start[8*pos[0] +: 8] = b;
                else if (pos < HEADER_LEN)
                    seen_id[8*pos[0] +: 8] = b;
                else if (data_mode) begin
                    r.payload = b;
                    pending.push_back(r);
                end
                else if (pos < PARAM_END)
                    seen_param[8*pos[1:0] +: 8] = b;
                else
                    seen_resp[8*pos[0] +: 8] = b;
                pos = pos + 17'd1;
            end
            else if (pos == chk_at) begin
                chk_low = b;
                pos = pos + 17'd1;
            end
            else begin
                // Any byte past the checksum low byte closes the packet.
                rx_chk = {b, chk_low};
                want_start = data_mode ? DATA_START : RESP_START;
                r.kind = KIND_STATUS;
                if (seen_start != want_start || seen_id != dev_id || rx_chk != sum)
                    r.status = STATUS_ERROR;
                else if (!data_mode) begin
                    r.status = (seen_resp == nack_code) ? STATUS_NACK : STATUS_ACK;
                    r.param  = seen_param;
                    r.code   = seen_resp;
                end
                pending.push_back(r);
                clear_packet();
            end
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(logic kind_bit, logic [OUT_DATA_W-1:0] data);
            sensor_result_t want;
            sensor_result_t got;
            logic [5:0]     fill;
            got.kind    = result_kind_t'(kind_bit);
            got.payload = data[7:0];
            got.status  = packet_status_t'(data[9:8]);
            got.param   = data[41:10];
            got.code    = data[57:42];
            fill        = data[63:58];
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: kind %0d data %016h", kind_bit, data);
                return;
            end
            want = pending.pop_front();
            if (want.kind == KIND_PAYLOAD)
                payloads++;
            else if (want.status == STATUS_ACK)
                acks++;
            else if (want.status == STATUS_NACK)
                nacks++;
            else
                errors++;
            if (got.kind !== want.kind || got.payload !== want.payload ||
                got.status !== want.status || got.param !== want.param ||
                got.code !== want.code || fill !== 6'd0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected kind %0d byte %02h status %0d param %08h code %04h",
                             want.kind, want.payload, want.status, want.param, want.code);
                    $display("          got kind %0d byte %02h status %0d param %08h code %04h fill %02h",
                             got.kind, got.payload, got.status, got.param, got.code, fill);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = REG_EXPECT_DATA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = 8'h00;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    sensor_link_scoreboard sb = new();
    int bytes_sent = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int tx_gap_max = 16;
    int rx_gap_max = 16;
    int rx_hold = 0;

    sensor_response_packet_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Monitor both channels and keep the stall counter for the watchdog.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_rx_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stalls per result, plus an occasional long hold-off.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            if (rx_hold > 0) begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(negedge clk); while (!m_axis_tvalid);
            @(posedge clk);
        end
    end

    function automatic logic [31:0] pick_word(int bits);
        logic [31:0] mask;
        int          r;
        mask = (bits >= 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 32'd1;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return mask;
        return $urandom & mask;
    endfunction

    // Offer one byte after a random gap and wait for its transaction.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        bytes_sent++;
    endtask

    // Stop sending, wait for every owed result, then let trailing bytes settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
        cfg_writes++;
        @(posedge clk);
    endtask

    // Append the additive checksum (optionally corrupted) and send the frame,
    // or only its first cut bytes when cut is not negative.
    task automatic send_frame(input logic [7:0] body[$], input logic [15:0] flip,
                              input int cut);
        logic [15:0] sum;
        logic [7:0]  frame[$];
        sum = 16'd0;
        foreach (body[i])
            sum = sum + 16'(body[i]);
        sum = sum ^ flip;
        frame = body;
        frame.push_back(sum[7:0]);
        frame.push_back(sum[15:8]);
        if (cut >= 0)
            frame = frame[0:cut-1];
        foreach (frame[i])
            send_byte(frame[i]);
    endtask

    // Build a packet for the current mode: mostly well formed, some with a
    // broken start code, device id or checksum, a few pure junk.
    task automatic send_packet(input int cut);
        logic [7:0]  body[$];
        logic [15:0] start;
        logic [15:0] id;
        logic [15:0] code;
        logic [15:0] flip;
        logic [31:0] param;
        int          r;
        int          n_pay;
        r = $urandom_range(0, 99);
        start = sb.data_mode ? DATA_START : RESP_START;
        id = sb.dev_id;
        flip = 16'd0;
        if (r < 6)
            start = start ^ (16'd1 << $urandom_range(0, 15));
        else if (r < 9)
            start = sb.data_mode ? RESP_START : DATA_START;
        else if (r < 15)
            id = id ^ (16'd1 << $urandom_range(0, 15));
        else if (r < 21)
            flip = 16'd1 << $urandom_range(0, 15);
        body = '{start[7:0], start[15:8], id[7:0], id[15:8]};
        if (sb.data_mode) begin
            n_pay = (sb.pay_len > 16'd24) ? 24 : int'(sb.pay_len);
            repeat (n_pay) body.push_back(8'($urandom));
        end
        else begin
            param = pick_word(32);
            code = ($urandom_range(0, 2) == 0) ? sb.nack_code : 16'(pick_word(16));
            body.push_back(param[7:0]);
            body.push_back(param[15:8]);
            body.push_back(param[23:16]);
            body.push_back(param[31:24]);
            body.push_back(code[7:0]);
            body.push_back(code[15:8]);
        end
        if (r >= 94) begin
            foreach (body[i])
                body[i] = 8'($urandom);
            flip = 16'($urandom);
        end
        send_frame(body, flip, cut);
    endtask

    // Stimulus: directed packets first, then random phases of settings.
    initial
    begin
        int   phase;
        int   n;
        logic mode;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Nack response with an all-ones parameter under the reset settings.
        send_frame('{8'h55, 8'hAA, 8'h01, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h31, 8'h00}, 16'd0, -1);
        // Data header sent in response mode, then the mode is switched
        // mid-packet so the header is followed straight by the checksum.
        send_frame('{8'h5A, 8'hA5, 8'h01, 8'h00}, 16'd0, 4);
        drain();
        write_reg(REG_EXPECT_DATA, 16'd1);
        write_reg(REG_PAYLOAD_LEN, 16'd0);
        send_byte(8'h00);
        send_byte(8'h01);
        // Response start codes while a data packet is expected.
        send_frame('{8'h55, 8'hAA, 8'h01, 8'h00}, 16'd0, -1);

        phase = 0;
        while (bytes_sent < ITEM_TARGET) begin
            drain();
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
            // Long receiver hold-off while the sender keeps pushing.
            if (phase == 2 || $urandom_range(0, 24) == 0) begin
                tx_gap_max = 0;
                rx_hold = LONG_HOLD;
            end
            if ($urandom_range(0, 9) == 0) begin
                // Start a very long data packet that a later setting cuts off.
                write_reg(REG_EXPECT_DATA, 16'd1);
                write_reg(REG_PAYLOAD_LEN, ($urandom_range(0, 1) == 0) ? 16'hFFFF :
                          16'($urandom_range(13, 65534)));
                send_packet($urandom_range(1, 24));
            end
            else begin
                mode = 1'($urandom_range(0, 1));
                write_reg(REG_EXPECT_DATA, 16'(mode));
                write_reg(REG_PAYLOAD_LEN, mode ? 16'($urandom_range(0, 12)) :
                          16'(pick_word(16)));
                write_reg(REG_DEVICE_ID, 16'(pick_word(16)));
                write_reg(REG_NACK_CODE, 16'(pick_word(16)));
                // Finish a packet that the previous phase left open.
                repeat (sb.bytes_to_close()) send_byte(8'($urandom));
                n = $urandom_range(1, 8);
                repeat (n) send_packet(-1);
                // Sometimes leave a packet open across the next register writes.
                if ($urandom_range(0, 6) == 0)
                    send_packet($urandom_range(1, int'(sb.check_pos()) + 1));
            end
            phase++;
        end
        drain();
        repeat (4) @(posedge clk);

        $display("Run covered %0d link bytes in %0d phases with %0d register writes.",
                 bytes_sent, phase, cfg_writes);
        $display("Results: %0d payload bytes, %0d ack, %0d nack, %0d error; %0d mismatches.",
                 sb.payloads, sb.acks, sb.nacks, sb.errors, sb.mismatches);
        if (sb.pending.size() != 0)
            $display("%0d expected results never arrived", sb.pending.size());
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
